// ----- hw/rtl/sqtw_pkg.sv -----
// ----------------------------------------------------------------------------
// sqtw_pkg: shared types and constants for the sleep queue
// Queue depth, index widths, operation and result codes, and the entry and
// control structures used between the cell row and the top level.
// ----------------------------------------------------------------------------
package sqtw_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int ID_W    = 8;
  localparam int TICKS_W = 32;

  // Operation codes carried in in_tuser.
  localparam logic [1:0] FUNC_PUT  = 2'd0;
  localparam logic [1:0] FUNC_GET  = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  // Result kinds carried in out_tuser.
  localparam logic [1:0] KIND_WOKEN    = 2'd0;
  localparam logic [1:0] KIND_GOT      = 2'd1;
  localparam logic [1:0] KIND_EMPTY    = 2'd2;
  localparam logic [1:0] KIND_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TICKS_W-1:0] limit;
    logic [TICKS_W-1:0] elapsed;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic             shift;
    logic [DEPTH-1:0] load;
  } chain_ctrl_t;

endpackage

// ----- hw/rtl/sleep_queue_tick_wakeup_unit.sv -----
// ----------------------------------------------------------------------------
// sleep_queue_tick_wakeup_unit: ordered sleep queue with tick wakeup
// Keeps up to DEPTH sleeping threads in a row of cells, appends on put,
// removes the head on get, and on a tick ages every entry and wakes those
// whose elapsed count reaches their limit.
// ----------------------------------------------------------------------------
//
// Channel   Direction  tuser                tdata                       tlast
// in_       slave      [1:0] func           [7:0] thread_id,            -
//                                           [39:8] sleep_ticks
// out_      master     [1:0] kind           [7:0] thread_id_out         last_of_run
//
// A put, a get, or a tick on an empty queue leaves the sequencer idle. Any
// other tick sweeps the queued entries in turn through the single
// age-and-compare unit at the head of the cell row, then closes the run in
// a flush state. Each woken entry costs one output word; a stalled output
// holds the sweep where it is. Reset clears the fill count, the sequencer,
// the pending flag and the output valid flag; the cells themselves are not
// cleared, as only entries below the fill count are ever read. A new word is
// taken only when the queue is idle and the output register is empty or
// being drained in that same cycle.
// ----------------------------------------------------------------------------
module sleep_queue_tick_wakeup_unit
  import sqtw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] thread_id, [39:8] sleep_ticks
  input  logic [1:0]  in_tuser,   // [1:0] func

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] thread_id_out
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last_of_run
);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_TICK  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;   // entries held, head first
  logic [CNT_W-1:0] rem_r, rem_nxt;       // entries still to age in this tick

  // A woken id is held back until the next one wakes or the sweep ends, so
  // that the final one of the run can be marked once no further entry wakes.
  logic             pend_v_r, pend_v_nxt;
  logic [ID_W-1:0]  pend_id_r, pend_id_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]  out_id_r, out_id_nxt;
  logic [1:0]       out_kind_r, out_kind_nxt;
  logic             out_last_r, out_last_nxt;

  logic               out_free;
  logic               in_acc;
  logic               step;
  logic [1:0]         func;
  logic [ID_W-1:0]    in_id;
  logic [TICKS_W-1:0] in_ticks;

  entry_t             head;
  entry_t             ins;
  chain_ctrl_t        cctl;
  logic [TICKS_W-1:0] head_e;
  logic               head_wake;
  logic [CNT_W-1:0]   count_m1;
  logic [IDX_W-1:0]   put_idx;
  logic [IDX_W-1:0]   tail_idx;

  assign func     = in_tuser;
  assign in_id    = in_tdata[ID_W-1:0];
  assign in_ticks = in_tdata[ID_W +: TICKS_W];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign step      = (state_r == ST_TICK) && out_free;

  // Age the head entry: the elapsed count saturates instead of wrapping.
  assign head_e    = (head.elapsed == '1) ? head.elapsed : head.elapsed + TICKS_W'(1);
  assign head_wake = (head_e >= head.limit);

  assign count_m1 = count_r - CNT_W'(1);
  assign put_idx  = count_r[IDX_W-1:0];
  assign tail_idx = count_m1[IDX_W-1:0];

  sqtw_chain u_chain (
    .clk    (clk),
    .ctrl   (cctl),
    .ins_i  (ins),
    .head_o (head)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    pend_v_nxt    = pend_v_r;
    pend_id_nxt   = pend_id_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_id_nxt    = out_id_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    cctl.shift    = 1'b0;
    cctl.load     = '0;
    ins.id        = in_id;
    ins.limit     = in_ticks;
    ins.elapsed   = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (func)
            FUNC_PUT: begin
              if (count_r == CNT_W'(DEPTH)) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_OVERFLOW;
                out_id_nxt    = '0;
                out_last_nxt  = 1'b1;
              end else begin
                cctl.load = DEPTH'(1) << put_idx;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            FUNC_GET: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              if (count_r == '0) begin
                out_kind_nxt = KIND_EMPTY;
                out_id_nxt   = '0;
              end else begin
                out_kind_nxt = KIND_GOT;
                out_id_nxt   = head.id;
                cctl.shift   = 1'b1;
                count_nxt    = count_m1;
              end
            end
            FUNC_TICK: begin
              if (count_r != '0) begin
                state_nxt = ST_TICK;
                rem_nxt   = count_r;
              end
            end
            default: begin
              // Unused operation code: taken and dropped.
            end
          endcase
        end
      end

      ST_TICK: begin
        if (step) begin
          // The head leaves its cell every step; a survivor goes back in at
          // the tail, so the queue order is kept.
          cctl.shift = 1'b1;
          rem_nxt    = rem_r - CNT_W'(1);
          if (head_wake) begin
            count_nxt   = count_m1;
            pend_v_nxt  = 1'b1;
            pend_id_nxt = head.id;
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_WOKEN;
              out_id_nxt    = pend_id_r;
              out_last_nxt  = 1'b0;
            end
          end else begin
            ins.id      = head.id;
            ins.limit   = head.limit;
            ins.elapsed = head_e;
            cctl.load   = DEPTH'(1) << tail_idx;
          end
          if (rem_r == CNT_W'(1)) begin
            state_nxt = ST_FLUSH;
          end
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_WOKEN;
            out_id_nxt    = pend_id_r;
            out_last_nxt  = 1'b1;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_id_r  <= pend_id_nxt;
    out_id_r   <= out_id_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_id_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count beyond queue depth");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TICK) |-> (rem_r != '0 && rem_r <= count_r))
    else $error("tick sweep counter out of range");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_v_r)
    else $error("woken id left pending after a tick");

  a_wake_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (step && head_wake) |=> (count_r == $past(count_m1)))
    else $error("woken entry not removed from the count");

  a_flush_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && out_free) |=> (state_r == ST_IDLE))
    else $error("tick run did not close");
`endif

endmodule

// ----- hw/rtl/sqtw_cell.sv -----
// ----------------------------------------------------------------------------
// sqtw_cell: one queue slot
// Holds one entry. It either loads the insert bus, takes the entry of its
// neighbor toward the tail, or keeps its contents.
// ----------------------------------------------------------------------------
module sqtw_cell
  import sqtw_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     nbr_i,
  input  entry_t     ins_i,
  output entry_t     q_o
);

  entry_t q_r;
  entry_t q_nxt;

  always_comb begin
    priority if (ctrl.load) begin
      q_nxt = ins_i;
    end else if (ctrl.shift) begin
      q_nxt = nbr_i;
    end else begin
      q_nxt = q_r;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q_o = q_r;

endmodule

// ----- hw/rtl/sqtw_chain.sv -----
// ----------------------------------------------------------------------------
// sqtw_chain: row of queue cells
// Cell 0 is the head. A shift moves every entry one place toward the head;
// a load writes the insert bus into the selected cell.
// ----------------------------------------------------------------------------
module sqtw_chain
  import sqtw_pkg::*;
(
  input  logic        clk,
  input  chain_ctrl_t ctrl,
  input  entry_t      ins_i,
  output entry_t      head_o
);

  entry_t q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t     nbr;
    cell_ctrl_t cc;

    // The tail cell has no neighbor; what it takes on a shift lies beyond
    // the fill count and is never read.
    if (i == DEPTH - 1) begin : g_tail
      assign nbr = ins_i;
    end else begin : g_mid
      assign nbr = q[i+1];
    end

    assign cc.shift = ctrl.shift;
    assign cc.load  = ctrl.load[i];

    sqtw_cell u_cell (
      .clk   (clk),
      .ctrl  (cc),
      .nbr_i (nbr),
      .ins_i (ins_i),
      .q_o   (q[i])
    );
  end

  assign head_o = q[0];

endmodule

// ----- test/tb_sleep_queue_tick_wakeup_unit.sv -----
// ----------------------------------------------------------------------------
// tb_sleep_queue_tick_wakeup_unit: self-checking bench for the sleep queue
// Drives put, get and tick words into the block and keeps its own copy of the
// queue to predict every result word. Each result is checked field by field.
// Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_sleep_queue_tick_wakeup_unit;
  import sqtw_pkg::*;

  // This operation code is not defined by the block. It must be dropped
  // without a result and without any change to the queue.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // The time budget allows for several times the slowest correct run. That run
  // is every tick waking a full queue while each output word waits out a long
  // stall.
  localparam int RUN_LIMIT = 4000000;

  // This many quiet cycles follow the last expected word, so that a stray late
  // word is still seen.
  localparam int DRAIN_CYCLES = 4 * DEPTH;

  typedef struct {
    logic [ID_W-1:0]    id;
    logic [TICKS_W-1:0] limit;
    logic [TICKS_W-1:0] elapsed;
  } sleeper_t;

  typedef struct {
    logic [1:0]      kind;
    logic [ID_W-1:0] id;
    logic            last;
  } wake_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  // This is the bench's own view of the queue, with the oldest sleeper at the
  // front. It also holds the result words that the block still owes, in order.
  sleeper_t   sleepers[$];
  wake_word_t expected_words[$];
  int         mismatch_count;

  // These switches turn the random idling on each side on or off, so that
  // some stretches run at full rate.
  bit in_gaps_on;
  bit out_stalls_on;

  sleep_queue_tick_wakeup_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #RUN_LIMIT;
    $display("Test completed with failures");
    $finish;
  end

  // Most gaps are zero or a few cycles. Now and then a long one is chosen.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // This applies one accepted input word to the bench's copy of the queue.
  // Any result words that it causes are appended to expected_words.
  function automatic void apply_to_sleep_queue(input logic [1:0] func,
                                               input logic [ID_W-1:0] tid,
                                               input logic [TICKS_W-1:0] ticks);
    sleeper_t   s;
    sleeper_t   survivors[$];
    wake_word_t w;
    int         woken;
    woken = 0;
    case (func)
      FUNC_PUT: begin
        if (sleepers.size() >= DEPTH) begin
          w.kind = KIND_OVERFLOW; w.id = '0; w.last = 1'b1;
          expected_words.push_back(w);
        end else begin
          s.id = tid; s.limit = ticks; s.elapsed = '0;
          sleepers.push_back(s);
        end
      end
      FUNC_GET: begin
        if (sleepers.size() == 0) begin
          w.kind = KIND_EMPTY; w.id = '0; w.last = 1'b1;
        end else begin
          s = sleepers.pop_front();
          w.kind = KIND_GOT; w.id = s.id; w.last = 1'b1;
        end
        expected_words.push_back(w);
      end
      FUNC_TICK: begin
        // Every sleeper ages by one tick, and the count holds at all ones
        // instead of wrapping. A sleeper wakes once its count reaches its
        // limit. The woken ids come out in queue order and the others stay.
        foreach (sleepers[i]) begin
          s = sleepers[i];
          if (s.elapsed != '1) s.elapsed = s.elapsed + 1'b1;
          if (s.elapsed >= s.limit) begin
            w.kind = KIND_WOKEN; w.id = s.id; w.last = 1'b0;
            expected_words.push_back(w);
            woken++;
          end else begin
            survivors.push_back(s);
          end
        end
        sleepers = survivors;
        if (woken > 0) expected_words[expected_words.size() - 1].last = 1'b1;
      end
      default: begin
      end
    endcase
  endfunction

  // This task starts and ends at a falling edge. Valid stays high across
  // back-to-back words and drops only when a gap is chosen.
  task automatic send_word(input logic [1:0] func, input logic [ID_W-1:0] tid,
                           input logic [TICKS_W-1:0] ticks);
    int gap;
    begin
      gap = in_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_tuser  = func;
      in_tdata  = {ticks, tid};
      in_tvalid = 1'b1;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      apply_to_sleep_queue(func, tid, ticks);
      @(negedge clk);
    end
  endtask

  // Output stalls: most of them are short and a few are long. With stalls
  // off, ready stays high.
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!out_stalls_on) begin
        stall_left = 0;
        out_tready = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        out_tready = 1'b0;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Every accepted output word is checked against the oldest expected word.
  always @(posedge clk) begin
    wake_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: expected no word, actual kind %0d id %0d last %0d", $time,
                 out_tuser, out_tdata, out_tlast);
        mismatch_count++;
      end else begin
        w = expected_words.pop_front();
        if (out_tuser !== w.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, w.kind, out_tuser);
          mismatch_count++;
        end
        if (out_tdata !== w.id) begin
          $display("%0t: thread id expected %0d actual %0d", $time, w.id, out_tdata);
          mismatch_count++;
        end
        if (out_tlast !== w.last) begin
          $display("%0t: last flag expected %0d actual %0d", $time, w.last, out_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // A get and a tick on an empty queue, and the undefined operation code.
  task automatic test_empty_queue();
    send_word(FUNC_GET, 8'h3C, 32'd7);
    send_word(FUNC_TICK, 8'hC3, 32'hFFFF_FFFF);
    send_word(FUNC_UNUSED, 8'hFF, 32'hFFFF_FFFF);
  endtask

  // This covers extreme ids and limits. A zero limit wakes on the first tick.
  // An all-ones limit never wakes within the run, so that sleeper leaves by a
  // get.
  task automatic test_limit_extremes();
    send_word(FUNC_PUT, 8'h00, 32'd0);
    send_word(FUNC_PUT, 8'hFF, 32'hFFFF_FFFF);
    send_word(FUNC_PUT, 8'hA5, 32'd1);
    send_word(FUNC_PUT, 8'h5A, 32'd2);
    send_word(FUNC_TICK, 8'h00, 32'd0);
    send_word(FUNC_GET, 8'h00, 32'd0);
    send_word(FUNC_TICK, 8'h00, 32'd0);
    send_word(FUNC_GET, 8'h00, 32'd0);
  endtask

  // This fills the queue, overflows it once and then wakes every entry with
  // one tick. That tick gives the longest run of results there can be.
  task automatic test_fill_and_overflow();
    for (int i = 0; i < DEPTH; i++) send_word(FUNC_PUT, 8'(i * 17 + 1), 32'd1);
    send_word(FUNC_PUT, 8'hEE, 32'd3);
    send_word(FUNC_TICK, 8'h00, 32'd0);
  endtask

  // Random traffic. Puts are favored while the queue is shallow, so that it
  // often runs full and then overflows. Most limits are a few ticks, so ticks
  // keep waking entries. Some limits are full 32-bit values. Ignored words do
  // not count toward num_words.
  task automatic test_random_traffic(input int num_words);
    int               sent;
    int               r;
    int               put_weight;
    logic [1:0]       func;
    logic [TICKS_W-1:0] ticks;
    sent = 0;
    while (sent < num_words) begin
      put_weight = (sleepers.size() < 4) ? 60 : 42;
      r = $urandom_range(0, 99);
      if (r < 3) func = FUNC_UNUSED;
      else if (r < 3 + put_weight) func = FUNC_PUT;
      else if (r < 3 + put_weight + 20) func = FUNC_GET;
      else func = FUNC_TICK;
      r = $urandom_range(0, 99);
      if (r < 70) ticks = $urandom_range(0, 5);
      else if (r < 85) ticks = $urandom_range(6, 40);
      else if (r < 95) ticks = $urandom();
      else ticks = '1;
      send_word(func, 8'($urandom_range(0, 255)), ticks);
      if (func != FUNC_UNUSED) sent++;
    end
  endtask

  initial begin
    mismatch_count = 0;
    in_gaps_on     = 1'b0;
    out_stalls_on  = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = FUNC_PUT;
    rst_n          = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_empty_queue();
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    test_limit_extremes();
    test_fill_and_overflow();
    // The first random stretch has no idling at all. The second idles on
    // both sides.
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    test_random_traffic(40);
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    test_random_traffic(90);
    in_tvalid = 1'b0;

    // The output is always ready from here on, so a stray word shows up at
    // once.
    out_stalls_on = 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sleep_queue_tick_wakeup_unit.f -----
hw/rtl/sqtw_pkg.sv
hw/rtl/sqtw_cell.sv
hw/rtl/sqtw_chain.sv
hw/rtl/sleep_queue_tick_wakeup_unit.sv
test/tb_sleep_queue_tick_wakeup_unit.sv
